// File: hw/rtl/edf_task_table_scheduler_assert.svh
// assertion macros for the edf task table scheduler
`ifndef EDF_TASK_TABLE_SCHEDULER_ASSERT_SVH
`define EDF_TASK_TABLE_SCHEDULER_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define EDF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define EDF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hw/rtl/edf_pkg.sv
`default_nettype none
package edf_pkg;
  localparam int DL_W = 31;
  localparam logic [DL_W-1:0] DL_MAX = {DL_W{1'b1}};

  typedef enum logic [1:0] {
    ST_DORMANT  = 2'd0,
    ST_READY    = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_SLEEPING = 2'd3
  } slot_st_t;

  typedef enum logic [2:0] {
    OP_CREATE   = 3'd0,
    OP_START    = 3'd1,
    OP_YIELD    = 3'd2,
    OP_SLEEP    = 3'd3,
    OP_PYIELD   = 3'd4,
    OP_SETDL    = 3'd5,
    OP_SCHEDULE = 3'd6,
    OP_BAD      = 3'd7
  } op_t;

  // per-slot write command broadcast from the controller to the cells
  typedef struct packed {
    logic     wr_state;
    slot_st_t state;
    logic     wr_init;
    logic     wr_cur;
    logic [DL_W-1:0] init_dl;
    logic [DL_W-1:0] cur_dl;
  } cell_wr_t;
endpackage
`default_nettype wire

// File: hw/rtl/edf_cell.sv
`default_nettype none
// one task slot: state plus two deadlines, and a shift-rotate link to its neighbour
module edf_cell #(
  parameter logic [1:0] RST_ST = 2'd0,
  parameter logic [30:0] RST_DL = 31'd0
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic rot,        // rotate the ring one place
  input  wire logic wr_en,      // apply write command to this slot
  input  wire edf_pkg::cell_wr_t wr,
  input  wire edf_pkg::slot_st_t nb_state,
  input  wire logic [30:0] nb_init,
  input  wire logic [30:0] nb_cur,
  output edf_pkg::slot_st_t state_o,
  output logic [30:0] init_o,
  output logic [30:0] cur_o
);
  import edf_pkg::*;
  slot_st_t st_r, st_nxt;
  logic [DL_W-1:0] init_r, init_nxt, cur_r, cur_nxt;

  always_comb begin
    st_nxt = st_r;
    init_nxt = init_r;
    cur_nxt = cur_r;
    if (rot) begin
      st_nxt = nb_state;
      init_nxt = nb_init;
      cur_nxt = nb_cur;
    end else if (wr_en) begin
      if (wr.wr_state) st_nxt = wr.state;
      if (wr.wr_init) init_nxt = wr.init_dl;
      if (wr.wr_cur) cur_nxt = wr.cur_dl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= slot_st_t'(RST_ST);
      init_r <= RST_DL;
      cur_r <= RST_DL;
    end else begin
      st_r <= st_nxt;
      init_r <= init_nxt;
      cur_r <= cur_nxt;
    end
  end

  assign state_o = st_r;
  assign init_o = init_r;
  assign cur_o = cur_r;
endmodule
`default_nettype wire

// File: hw/rtl/edf_task_table_scheduler.sv
`default_nettype none
// throughput: one operation at a time; busy stays high until the result strobe
// the scan rotates the ring of slot cells once round, one slot a cycle past slot 0's seat
// reset: synchronous active-low; slot 0 ready with the maximum deadline, others dormant
// results cannot be stalled: out_valid is a one-cycle strobe
module edf_task_table_scheduler #(
  parameter int TASK_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_operation,
  input  wire logic [30:0] in_deadline,
  input  wire logic [3:0]  in_target_id,
  input  wire logic [30:0] in_sleep_time,
  output logic             out_valid,
  output logic             out_status,
  output logic [3:0]       out_task_id,
  output logic             out_preempt,
  output logic [3:0]       out_current_id
);
  import edf_pkg::*;

  localparam int IW = $clog2(TASK_SLOTS);   // slot index width
  localparam int CW = IW + 1;               // counter / count width

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EXEC = 4'b0100,
    S_DONE = 4'b1000
  } fsm_t;

  fsm_t fsm_r, fsm_nxt;

  // latched command
  op_t             op_r;
  logic [DL_W-1:0] dl_r, slp_r;
  logic [3:0]      tgt_r;

  // control state
  logic          run_vld_r, run_vld_nxt;   // running slot is not none
  logic [IW-1:0] run_r, run_nxt;
  logic [CW-1:0] live_r, live_nxt;
  logic          started_r, started_nxt;

  // scan state
  logic [CW-1:0]   cnt_r;                  // ring position: slot at cell 0
  logic            hit_r;
  logic [IW-1:0]   pick_r;
  logic [DL_W-1:0] best_r;

  // ring of cells
  slot_st_t        c_st   [TASK_SLOTS];
  logic [DL_W-1:0] c_init [TASK_SLOTS];
  logic [DL_W-1:0] c_cur  [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] c_wen;
  cell_wr_t        wr_cmd;
  cell_wr_t        wr_mux [TASK_SLOTS];
  logic            rot;

  genvar g;
  generate
    for (g = 0; g < TASK_SLOTS; g++) begin : g_cell
      edf_cell #(
        .RST_ST(g == 0 ? ST_READY : ST_DORMANT),
        .RST_DL(g == 0 ? DL_MAX : 31'd0)
      ) u_cell (
        .clk(clk), .rst_n(rst_n), .rot(rot), .wr_en(c_wen[g]), .wr(wr_mux[g]),
        .nb_state(c_st[(g + 1) % TASK_SLOTS]),
        .nb_init(c_init[(g + 1) % TASK_SLOTS]),
        .nb_cur(c_cur[(g + 1) % TASK_SLOTS]),
        .state_o(c_st[g]), .init_o(c_init[g]), .cur_o(c_cur[g])
      );
    end
  endgenerate

  // the slot passing cell 0 during the scan
  logic [IW-1:0] scan_idx;
  assign scan_idx = cnt_r[IW-1:0];

  // caller: running slot when started, valid and still running
  logic          caller_ok;
  logic [IW-1:0] caller;
  assign caller_ok = started_r && run_vld_r && (c_st[run_r] == ST_RUNNING);
  assign caller = caller_ok ? run_r : '0;

  // execute-stage decisions (ring at home position)
  logic          ex_status, ex_pre, tgt_bad;
  logic [IW-1:0] ex_tid, wr_slot, wr_slot2;
  logic          wr_en1, wr_en2;
  slot_st_t      st2;
  logic [CW-1:0] tgt_ext;
  assign tgt_ext = CW'(tgt_r);
  assign tgt_bad = (tgt_ext >= CW'(TASK_SLOTS));

  logic [IW-1:0] tgt_idx;
  assign tgt_idx = IW'(tgt_r);

  always_comb begin
    ex_status = 1'b0;
    ex_pre = 1'b0;
    ex_tid = '0;
    wr_slot = '0;
    wr_slot2 = caller;
    wr_en1 = 1'b0;
    wr_en2 = 1'b0;
    st2 = ST_READY;
    wr_cmd = '0;
    run_vld_nxt = run_vld_r;
    run_nxt = run_r;
    live_nxt = live_r;
    started_nxt = started_r;
    case (op_r)
      OP_CREATE: begin
        if (!hit_r || dl_r == '0 || live_r >= CW'(TASK_SLOTS)) begin
          ex_status = 1'b1;
        end else begin
          wr_slot = pick_r;
          wr_en1 = 1'b1;
          wr_cmd.wr_state = 1'b1;
          wr_cmd.state = ST_READY;
          wr_cmd.wr_init = 1'b1;
          wr_cmd.wr_cur = 1'b1;
          wr_cmd.init_dl = dl_r;
          wr_cmd.cur_dl = dl_r;
          live_nxt = live_r + 1'b1;
          ex_tid = pick_r;
          if (caller_ok && caller != '0 && dl_r < c_cur[caller]) begin
            wr_en2 = 1'b1;
            ex_pre = 1'b1;
          end
        end
      end
      OP_START: begin
        if (started_r || c_st[1] != ST_READY) begin
          ex_status = 1'b1;
        end else begin
          wr_slot = pick_r;
          wr_en1 = 1'b1;
          wr_cmd.wr_state = 1'b1;
          wr_cmd.state = ST_RUNNING;
          run_vld_nxt = 1'b1;
          run_nxt = pick_r;
          started_nxt = 1'b1;
          ex_tid = pick_r;
        end
      end
      OP_YIELD, OP_SLEEP, OP_PYIELD: begin
        if (run_vld_r) begin
          wr_slot = caller;
          wr_en1 = 1'b1;
          wr_cmd.wr_state = 1'b1;
          wr_cmd.state = (op_r == OP_YIELD) ? ST_READY : ST_SLEEPING;
          wr_cmd.wr_cur = (op_r != OP_PYIELD);
          wr_cmd.cur_dl = (op_r == OP_YIELD) ? c_init[caller] : slp_r;
          run_vld_nxt = 1'b0;
          ex_pre = 1'b1;
        end
      end
      OP_SETDL: begin
        if (dl_r == '0 || tgt_bad || tgt_idx == caller || tgt_r == 4'd0 ||
            c_st[tgt_idx] == ST_DORMANT) begin
          ex_status = 1'b1;
        end else begin
          wr_slot = tgt_idx;
          wr_en1 = 1'b1;
          wr_cmd.wr_init = 1'b1;
          wr_cmd.wr_cur = 1'b1;
          wr_cmd.init_dl = dl_r;
          wr_cmd.cur_dl = dl_r;
          if (dl_r <= c_cur[caller]) begin
            wr_en2 = 1'b1;
            run_vld_nxt = 1'b0;
            ex_pre = 1'b1;
          end
        end
      end
      OP_SCHEDULE: begin
        wr_slot = pick_r;
        wr_en1 = 1'b1;
        wr_cmd.wr_state = 1'b1;
        wr_cmd.state = ST_RUNNING;
        run_vld_nxt = 1'b1;
        run_nxt = pick_r;
        ex_tid = pick_r;
      end
      default: begin
        ex_status = 1'b1;
      end
    endcase
  end

  // second write only touches the caller's state (to ready); it never shares
  // a slot with the first write
  cell_wr_t wr2_cmd;
  always_comb begin
    wr2_cmd = '0;
    wr2_cmd.wr_state = 1'b1;
    wr2_cmd.state = st2;
  end

  // per-cell write enable; where both writes hit one cell, the first write's command is used
  logic in_exec;
  assign in_exec = (fsm_r == S_EXEC);
  always_comb begin
    for (int k = 0; k < TASK_SLOTS; k++) begin
      c_wen[k] = in_exec && ((wr_en1 && wr_slot == IW'(k)) ||
                             (wr_en2 && wr_slot2 == IW'(k)));
    end
  end

  // the cells share one command bus; the caller's ready write is folded in
  // when it lands on a different cell by giving it state-only semantics
  cell_wr_t bus;
  always_comb begin
    bus = wr_cmd;
  end
  // fold: cells hit only by the second write must see state-only ready
  logic [TASK_SLOTS-1:0] only2;
  always_comb begin
    for (int k = 0; k < TASK_SLOTS; k++) begin
      only2[k] = wr_en2 && wr_slot2 == IW'(k) && !(wr_en1 && wr_slot == IW'(k));
      wr_mux[k] = only2[k] ? wr2_cmd : bus;
    end
  end

  // scan step: test the slot now in cell 0
  logic scan_better;
  always_comb begin
    scan_better = 1'b0;
    case (op_r)
      OP_CREATE:   scan_better = !hit_r && c_st[0] == ST_DORMANT;
      OP_START:    scan_better = cnt_r >= CW'(2) && c_st[0] == ST_READY &&
                                 c_cur[0] < best_r;
      OP_SCHEDULE: scan_better = scan_idx != '0 && c_st[0] == ST_READY &&
                                 c_cur[0] < best_r;
      default:     scan_better = 1'b0;
    endcase
  end

  logic scan_last;
  assign scan_last = (cnt_r == CW'(TASK_SLOTS - 1));
  assign rot = (fsm_r == S_SCAN);

  always_comb begin
    fsm_nxt = fsm_r;
    case (fsm_r)
      S_IDLE: if (start) fsm_nxt = (op_t'(in_operation) == OP_CREATE ||
                                    op_t'(in_operation) == OP_START ||
                                    op_t'(in_operation) == OP_SCHEDULE) ? S_SCAN : S_EXEC;
      S_SCAN: if (scan_last) fsm_nxt = S_EXEC;
      S_EXEC: fsm_nxt = S_DONE;
      S_DONE: fsm_nxt = S_IDLE;
      default: fsm_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r <= S_IDLE;
      run_vld_r <= 1'b0;
      run_r <= '0;
      live_r <= CW'(1);
      started_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      fsm_r <= fsm_nxt;
      out_valid <= 1'b0;
      if (in_exec) begin
        run_vld_r <= run_vld_nxt;
        run_r <= run_nxt;
        live_r <= live_nxt;
        started_r <= started_nxt;
      end
      if (fsm_r == S_DONE) out_valid <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (fsm_r == S_IDLE && start) begin
      op_r <= op_t'(in_operation);
      dl_r <= in_deadline;
      slp_r <= in_sleep_time;
      tgt_r <= in_target_id;
      cnt_r <= '0;
      hit_r <= 1'b0;
      pick_r <= (op_t'(in_operation) == OP_START) ? IW'(1) : '0;
      best_r <= DL_MAX;
    end else if (fsm_r == S_SCAN) begin
      cnt_r <= cnt_r + 1'b1;
      if (scan_better || (op_r == OP_START && scan_idx == IW'(1))) begin
        hit_r <= 1'b1;
        pick_r <= scan_idx;
        best_r <= c_cur[0];
      end
    end
    if (in_exec) begin
      out_status <= ex_status;
      out_task_id <= 4'(ex_tid);
      out_preempt <= ex_pre;
    end
  end

  // current id after the write lands
  always_ff @(posedge clk) begin
    if (fsm_r == S_DONE) out_current_id <= 4'(caller);
  end

  assign busy = (fsm_r != S_IDLE);
endmodule
`default_nettype wire

// File: hw/rtl/edf_chk.sv
`default_nettype none
`include "edf_task_table_scheduler_assert.svh"
module edf_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic       out_status,
  input wire logic [3:0] out_task_id,
  input wire logic       out_preempt
);
  `EDF_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy, "busy not raised")
  `EDF_ASSERT_IMP(a_strobe_busy, clk, rst_n, out_valid, !busy, "strobe while busy")
  `EDF_ASSERT_IMP(a_err_tid, clk, rst_n, out_valid && out_status, out_task_id == 4'd0 && !out_preempt, "error with payload")
  `EDF_ASSERT_NXT(a_one_strobe, clk, rst_n, out_valid, !out_valid, "double strobe")
endmodule
bind edf_task_table_scheduler edf_chk u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_task_id(out_task_id), .out_preempt(out_preempt)
);
`default_nettype wire

// File: test/edf_task_table_scheduler_checker.sv
`timescale 1ns / 1ps
module edf_task_table_scheduler_checker #(
  parameter int TASK_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [2:0]  in_operation,
  input  wire logic [30:0] in_deadline,
  input  wire logic [3:0]  in_target_id,
  input  wire logic [30:0] in_sleep_time,
  input  wire logic        out_valid,
  input  wire logic        out_status,
  input  wire logic [3:0]  out_task_id,
  input  wire logic        out_preempt,
  input  wire logic [3:0]  out_current_id,
  output int               fail_count,
  output int               pending_count
);
  import edf_pkg::*;

  typedef struct packed {
    logic       status;
    logic [3:0] task_id;
    logic       preempt;
    logic [3:0] current_id;
  } sched_reply_t;

  slot_st_t        slot_st   [TASK_SLOTS];
  logic [DL_W-1:0] base_dl   [TASK_SLOTS];
  logic [DL_W-1:0] live_dl   [TASK_SLOTS];
  int              run_slot;
  int              prev_run_slot;
  int              live_tasks;
  logic            kernel_up;
  sched_reply_t    reply_q[$];

  assign pending_count = reply_q.size();

  function automatic int caller();
    if (kernel_up && run_slot >= 0 && run_slot < TASK_SLOTS &&
        slot_st[run_slot] == ST_RUNNING) return run_slot;
    return 0;
  endfunction

  task automatic drop_runner(input slot_st_t ns, input logic load, input logic [DL_W-1:0] dl);
    int c;
    c = caller();
    slot_st[c] = ns;
    if (load) live_dl[c] = dl;
    prev_run_slot = run_slot;
    run_slot = -1;
  endtask

  task automatic table_reset();
    for (int i = 0; i < TASK_SLOTS; i++) begin
      slot_st[i] = ST_DORMANT;
      base_dl[i] = '0;
      live_dl[i] = '0;
    end
    slot_st[0] = ST_READY;
    base_dl[0] = DL_MAX;
    live_dl[0] = DL_MAX;
    run_slot = -1;
    prev_run_slot = -1;
    live_tasks = 1;
    kernel_up = 1'b0;
  endtask

  task automatic apply_op(input op_t op, input logic [DL_W-1:0] dl, input logic [3:0] tgt,
                          input logic [DL_W-1:0] slp, output sched_reply_t r);
    int c;
    int pick;
    logic [DL_W-1:0] best;
    r = '0;
    case (op)
      OP_CREATE: begin
        pick = -1;
        if (dl != 0 && live_tasks < TASK_SLOTS)
          for (int i = 0; i < TASK_SLOTS; i++)
            if (slot_st[i] == ST_DORMANT) begin
              pick = i;
              break;
            end
        if (pick < 0) r.status = 1'b1;
        else begin
          slot_st[pick] = ST_READY;
          base_dl[pick] = dl;
          live_dl[pick] = dl;
          live_tasks++;
          r.task_id = pick[3:0];
          c = caller();
          if (kernel_up && c > 0 && dl < live_dl[c]) begin
            slot_st[c] = ST_READY;
            r.preempt = 1'b1;
          end
        end
      end
      OP_START: begin
        if (kernel_up || slot_st[1] != ST_READY) r.status = 1'b1;
        else begin
          pick = 1;
          for (int i = 2; i < TASK_SLOTS; i++)
            if (slot_st[i] == ST_READY && live_dl[i] < live_dl[pick]) pick = i;
          slot_st[pick] = ST_RUNNING;
          prev_run_slot = pick;
          run_slot = pick;
          kernel_up = 1'b1;
          r.task_id = pick[3:0];
        end
      end
      OP_YIELD: if (run_slot >= 0) begin
        c = caller();
        drop_runner(ST_READY, 1'b1, base_dl[c]);
        r.preempt = 1'b1;
      end
      OP_SLEEP: if (run_slot >= 0) begin
        drop_runner(ST_SLEEPING, 1'b1, slp);
        r.preempt = 1'b1;
      end
      OP_PYIELD: if (run_slot >= 0) begin
        drop_runner(ST_SLEEPING, 1'b0, '0);
        r.preempt = 1'b1;
      end
      OP_SETDL: begin
        c = caller();
        if (dl == 0 || int'(tgt) == c || tgt == 0 || int'(tgt) >= TASK_SLOTS ||
            slot_st[tgt] == ST_DORMANT)
          r.status = 1'b1;
        else begin
          base_dl[tgt] = dl;
          live_dl[tgt] = dl;
          if (dl <= live_dl[c]) begin
            slot_st[c] = ST_READY;
            prev_run_slot = run_slot;
            run_slot = -1;
            r.preempt = 1'b1;
          end
        end
      end
      OP_SCHEDULE: begin
        pick = 0;
        best = DL_MAX;
        for (int i = 1; i < TASK_SLOTS; i++)
          if (slot_st[i] == ST_READY && live_dl[i] < best) begin
            pick = i;
            best = live_dl[i];
          end
        slot_st[pick] = ST_RUNNING;
        run_slot = pick;
        r.task_id = pick[3:0];
      end
      default: r.status = 1'b1;
    endcase
    r.current_id = 4'(caller());
  endtask

  always @(posedge clk) begin
    sched_reply_t got, want;
    if (!rst_n) begin
      table_reset();
      reply_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        got = '{out_status, out_task_id, out_preempt, out_current_id};
        if (reply_q.size() == 0) begin
          $error("result beat with nothing outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = reply_q.pop_front();
          if (got != want) begin
            fail_count <= fail_count + 1;
            if (got.status != want.status)
              $error("status: expected %0d, got %0d", want.status, got.status);
            if (got.task_id != want.task_id)
              $error("task_id: expected %0d, got %0d", want.task_id, got.task_id);
            if (got.preempt != want.preempt)
              $error("preempt: expected %0d, got %0d", want.preempt, got.preempt);
            if (got.current_id != want.current_id)
              $error("current_id: expected %0d, got %0d", want.current_id, got.current_id);
          end
        end
      end
      if (start && !busy) begin
        apply_op(op_t'(in_operation), in_deadline, in_target_id, in_sleep_time, want);
        reply_q.push_back(want);
      end
    end
  end

endmodule

// File: test/edf_task_table_scheduler_test.sv
`timescale 1ns / 1ps
module edf_task_table_scheduler_test;
  import edf_pkg::*;

  localparam int TASK_SLOTS = 16;
  localparam int RANDOM_BEATS = 930;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_operation = '0;
  logic [30:0] in_deadline = '0;
  logic [3:0]  in_target_id = '0;
  logic [30:0] in_sleep_time = '0;
  logic        out_valid;
  logic        out_status;
  logic [3:0]  out_task_id;
  logic        out_preempt;
  logic [3:0]  out_current_id;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  bit          no_gaps = 1'b0;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  edf_task_table_scheduler #(.TASK_SLOTS(TASK_SLOTS)) u_dut (
    .clk, .rst_n, .start, .busy,
    .in_operation, .in_deadline, .in_target_id, .in_sleep_time,
    .out_valid, .out_status, .out_task_id, .out_preempt, .out_current_id
  );

  edf_task_table_scheduler_checker #(.TASK_SLOTS(TASK_SLOTS)) u_checker (
    .clk, .rst_n, .start, .busy,
    .in_operation, .in_deadline, .in_target_id, .in_sleep_time,
    .out_valid, .out_status, .out_task_id, .out_preempt, .out_current_id,
    .fail_count, .pending_count
  );

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("edf_task_table_scheduler verification failed");
      $finish;
    end
  end

  // idle gap: mostly none or short, now and then long, none at all in a burst
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // deadlines: small values give ties, the extremes and full range now and then
  function automatic logic [30:0] pick_deadline();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 12) return DL_MAX;
    if (r < 70) return 31'($urandom_range(1, 40));
    return 31'($urandom);
  endfunction

  // present one beat and hold it until the block takes it, then maybe idle
  task automatic send_beat(input op_t op, input logic [30:0] dl, input logic [3:0] tgt,
                           input logic [30:0] slp);
    int gap;
    start <= 1'b1;
    in_operation <= op;
    in_deadline <= dl;
    in_target_id <= tgt;
    in_sleep_time <= slp;
    do @(posedge clk); while (busy);
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      // scramble the idle payload so it never leaks into a check
      in_operation <= 3'($urandom);
      in_deadline <= 31'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int r;
    op_t op;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: error paths before the kernel runs, then creates, start and calls on the running kernel
    send_beat(OP_START, 31'd5, 4'd0, 31'd0);         // slot 1 still dormant
    send_beat(OP_CREATE, 31'd0, 4'd0, 31'd0);        // zero deadline rejected
    send_beat(OP_BAD, DL_MAX, 4'hf, DL_MAX);         // unknown operation
    send_beat(OP_YIELD, 31'd0, 4'd0, 31'd0);         // nothing running
    send_beat(OP_SLEEP, 31'd0, 4'd0, DL_MAX);
    send_beat(OP_PYIELD, 31'd0, 4'd0, 31'd0);
    send_beat(OP_SETDL, 31'd9, 4'd0, 31'd0);         // idle slot as target
    send_beat(OP_SETDL, 31'd9, 4'd3, 31'd0);         // dormant target
    send_beat(OP_CREATE, DL_MAX, 4'd0, 31'd0);
    send_beat(OP_CREATE, 31'd1, 4'd0, 31'd0);
    send_beat(OP_CREATE, 31'd1, 4'd0, 31'd0);        // tie with the one before
    send_beat(OP_START, 31'd0, 4'd0, 31'd0);
    send_beat(OP_START, 31'd0, 4'd0, 31'd0);         // already started
    send_beat(OP_SETDL, 31'd4, 4'd2, 31'd0);         // target is the caller
    send_beat(OP_SETDL, 31'd0, 4'd3, 31'd0);         // zero deadline
    send_beat(OP_SETDL, 31'd1, 4'd3, 31'd0);         // at caller's deadline: preempt
    send_beat(OP_SCHEDULE, 31'd0, 4'd0, 31'd0);
    send_beat(OP_YIELD, 31'd0, 4'd0, 31'd0);
    send_beat(OP_SCHEDULE, 31'd0, 4'd0, 31'd0);
    send_beat(OP_CREATE, 31'd0 + 31'd0 + 31'd0 + 31'h0 | 31'd0 ? 31'd1 : 31'd0 + 31'd0 + 31'd0
              + 31'd0 + 31'd0 + 31'd0 + 31'd0 + 31'd0 + 31'd0 + 31'd0 + 31'd0 + 31'd0 + 31'd0
              + 31'd0 + 31'd0 + 31'd0, 4'd0, 31'd0); // create with a zero deadline again
    send_beat(OP_SLEEP, 31'd0, 4'd0, DL_MAX);
    send_beat(OP_SCHEDULE, 31'd0, 4'd0, 31'd0);
    send_beat(OP_PYIELD, 31'd0, 4'd0, 31'd0);
    send_beat(OP_SCHEDULE, 31'd0, 4'd0, 31'd0);

    // random: schedule-heavy traffic, the table fills and stays full
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 16) op = OP_CREATE;
      else if (r < 18) op = OP_START;
      else if (r < 30) op = OP_YIELD;
      else if (r < 40) op = OP_SLEEP;
      else if (r < 48) op = OP_PYIELD;
      else if (r < 64) op = OP_SETDL;
      else if (r < 97) op = OP_SCHEDULE;
      else op = OP_BAD;
      send_beat(op, pick_deadline(), 4'($urandom), pick_deadline());
    end
    start <= 1'b0;

    // drain, then let the block settle
    while (pending_count != 0) @(posedge clk);
    repeat (TASK_SLOTS + 8) @(posedge clk);
    if (fail_count == 0) $display("edf_task_table_scheduler verification clean");
    else $display("edf_task_table_scheduler verification failed");
    $finish;
  end

endmodule
